[rtl/pgcf_pkg.sv]
// Shared types and constants for the periodic grid cell fold block.
`timescale 1ns / 1ps
`default_nettype none
package pgcf_pkg;

  localparam int FOLD_W  = 10;
  localparam int CELL_W  = 10;
  localparam int SIZE_W  = 11;
  localparam int RAD_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd3;

  localparam logic OP_RESOLVE = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  // Control that travels beside the divider lanes.
  typedef struct packed {
    logic valid;
    logic wr;
    logic wr_ok;
  } ctl_t;

endpackage
`default_nettype wire

[rtl/pgcf_lane.sv]
// One axis: pipelined restoring floor divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module pgcf_lane #(
  parameter int IB = 17,
  parameter int GB = 11
) (
  input  wire logic                 clk,
  input  wire logic                 move,
  input  wire logic signed [IB-1:0] index,
  input  wire logic [GB-1:0]        size,
  output logic [IB-2:0]             quo,
  output logic                      neg,
  output logic [GB-1:0]             fold
);

  localparam int QB = IB - 1;

  logic [GB-1:0] rem_q [QB];
  logic [QB-1:0] num_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic          neg_q [QB];

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_stage
      logic [GB-1:0] rem_in;
      logic [QB-1:0] num_in;
      logic [QB-1:0] quo_in;
      logic          neg_in;
      logic [GB:0]   trial;
      logic          ge;
      logic [GB:0]   diff;

      if (k == 0) begin : g_first
        // A negative index x divides as ~x = -x-1 and is corrected at the end.
        assign neg_in = index[IB-1];
        assign num_in = index[IB-1] ? ~index[QB-1:0] : index[QB-1:0];
        assign rem_in = '0;
        assign quo_in = '0;
      end else begin : g_next
        assign neg_in = neg_q[k-1];
        assign num_in = num_q[k-1];
        assign rem_in = rem_q[k-1];
        assign quo_in = quo_q[k-1];
      end

      assign trial = {rem_in, num_in[QB-1]};
      assign ge    = trial >= {1'b0, size};
      assign diff  = trial - {1'b0, size};

      always_ff @(posedge clk) begin
        if (move) begin
          rem_q[k] <= ge ? diff[GB-1:0] : trial[GB-1:0];
          num_q[k] <= {num_in[QB-2:0], 1'b0};
          quo_q[k] <= {quo_in[QB-2:0], ge};
          neg_q[k] <= neg_in;
        end
      end
    end
  endgenerate

  assign quo  = quo_q[QB-1];
  assign neg  = neg_q[QB-1];
  assign fold = neg_q[QB-1] ? (size - GB'(1) - rem_q[QB-1]) : rem_q[QB-1];

endmodule
`default_nettype wire

[rtl/pgcf_merge.sv]
// Merge stage: range check, cell table access and the output register.
`timescale 1ns / 1ps
`default_nettype none
module pgcf_merge #(
  parameter int QB = 16,
  parameter int GB = 11,
  parameter int OW = 3,
  parameter int AW = 9,
  parameter int R  = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        move,
  input  wire pgcf_pkg::ctl_t              ctl,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [pgcf_pkg::CELL_W-1:0] wdata,
  input  wire logic [QB-1:0]               rad,
  input  wire logic [QB-1:0]               quo_a,
  input  wire logic [QB-1:0]               quo_b,
  input  wire logic [QB-1:0]               quo_c,
  input  wire logic                        neg_a,
  input  wire logic                        neg_b,
  input  wire logic                        neg_c,
  input  wire logic [GB-1:0]               rem_a,
  input  wire logic [GB-1:0]               rem_b,
  input  wire logic [GB-1:0]               rem_c,
  output logic                             out_valid,
  output logic                             outside,
  output logic [pgcf_pkg::CELL_W-1:0]      cell_number,
  output logic [GB-1:0]                    fold_a,
  output logic [GB-1:0]                    fold_b,
  output logic [GB-1:0]                    fold_c
);

  localparam int S     = 2 * R + 1;
  localparam int DEPTH = S * S * S;
  localparam logic [AW-1:0] SIDE = AW'(S);
  localparam logic [OW-1:0] OFS  = OW'(R);

  logic [pgcf_pkg::CELL_W-1:0] mem [DEPTH];
  logic [pgcf_pkg::CELL_W-1:0] rd;
  logic                        out_a, out_b, out_c, outside_n;
  logic [OW-1:0]               ca, cb, cc;
  logic [AW-1:0]               raddr;

  // A negative quotient -(q+1) has magnitude q+1.
  assign out_a = neg_a ? (quo_a >= rad) : (quo_a > rad);
  assign out_b = neg_b ? (quo_b >= rad) : (quo_b > rad);
  assign out_c = neg_c ? (quo_c >= rad) : (quo_c > rad);
  assign outside_n = out_a | out_b | out_c;

  assign ca = neg_a ? (OFS - OW'(1) - quo_a[OW-1:0]) : (OFS + quo_a[OW-1:0]);
  assign cb = neg_b ? (OFS - OW'(1) - quo_b[OW-1:0]) : (OFS + quo_b[OW-1:0]);
  assign cc = neg_c ? (OFS - OW'(1) - quo_c[OW-1:0]) : (OFS + quo_c[OW-1:0]);
  assign raddr = (AW'(ca) * SIDE + AW'(cb)) * SIDE + AW'(cc);

  always_ff @(posedge clk) begin
    if (move && ctl.valid && ctl.wr && ctl.wr_ok) begin
      mem[waddr] <= wdata;
    end
    if (move) begin
      rd      <= mem[raddr];
      outside <= outside_n;
      fold_a  <= rem_a;
      fold_b  <= rem_b;
      fold_c  <= rem_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= ctl.valid && !ctl.wr;
    end
  end

  assign cell_number = outside ? '0 : rd;

endmodule
`default_nettype wire

[rtl/periodic_grid_cell_fold.sv]
// Each axis has one divider stage per quotient bit; the merge register follows.
// Throughput: one word per cycle while no finished result word is held.
// Table write words take the same path and give no result.
// Reset clears the pipeline valids and sets grid sizes to 1 and radius to 1.
// The cell table is not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none
module periodic_grid_cell_fold #(
  parameter int MAX_GRID   = 1024,
  parameter int MAX_RADIUS = 3,
  parameter int INDEX_BITS = 17
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [pgcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pgcf_pkg::SIZE_W-1:0]          cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 op,
  input  wire logic signed [INDEX_BITS-1:0]         index_a,
  input  wire logic signed [INDEX_BITS-1:0]         index_b,
  input  wire logic signed [INDEX_BITS-1:0]         index_c,
  input  wire logic [pgcf_pkg::CELL_W-1:0]          entry_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      outside,
  output logic [pgcf_pkg::CELL_W-1:0]               cell_number,
  output logic [pgcf_pkg::FOLD_W-1:0]               fold_a,
  output logic [pgcf_pkg::FOLD_W-1:0]               fold_b,
  output logic [pgcf_pkg::FOLD_W-1:0]               fold_c
);

  localparam int IB = INDEX_BITS;
  localparam int QB = IB - 1;
  localparam int GB = $clog2(MAX_GRID + 1);
  localparam int S  = 2 * MAX_RADIUS + 1;
  localparam int OW = $clog2(S);
  localparam int AW = $clog2(S * S * S);
  localparam int FW = pgcf_pkg::FOLD_W;
  localparam int SW = pgcf_pkg::SIZE_W;
  localparam logic [AW-1:0] SIDE = AW'(S);
  localparam logic signed [IB-1:0] RLIM = IB'(MAX_RADIUS);

  logic [SW-1:0]            size_a, size_b, size_c;
  logic [pgcf_pkg::RAD_W-1:0] radius;
  logic [GB-1:0]            eff_a, eff_b, eff_c;
  logic [QB-1:0]            rad;
  logic                     move;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_a <= SW'(1);
      size_b <= SW'(1);
      size_c <= SW'(1);
      radius <= pgcf_pkg::RAD_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        pgcf_pkg::REG_GRID_A: size_a <= cfg_data;
        pgcf_pkg::REG_GRID_B: size_b <= cfg_data;
        pgcf_pkg::REG_GRID_C: size_c <= cfg_data;
        pgcf_pkg::REG_RADIUS: radius <= cfg_data[pgcf_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // A size of zero acts as one and sizes beyond the maximum are clamped.
  always_comb begin
    eff_a = (size_a == '0) ? GB'(1) :
            (32'(size_a) > 32'(MAX_GRID)) ? GB'(MAX_GRID) : GB'(size_a);
    eff_b = (size_b == '0) ? GB'(1) :
            (32'(size_b) > 32'(MAX_GRID)) ? GB'(MAX_GRID) : GB'(size_b);
    eff_c = (size_c == '0) ? GB'(1) :
            (32'(size_c) > 32'(MAX_GRID)) ? GB'(MAX_GRID) : GB'(size_c);
    rad   = (32'(radius) > 32'(MAX_RADIUS)) ? QB'(MAX_RADIUS) : QB'(radius);
  end

  // The whole pipeline advances together unless a finished word is held.
  assign move     = !(out_valid && out_stall);
  assign in_stall = !move;

  // Write address and table range check, taken at entry.
  pgcf_pkg::ctl_t          ctl_in;
  logic [OW-1:0]           wa, wb, wc;
  logic [AW-1:0]           waddr_in;

  assign wa = OW'(index_a + RLIM);
  assign wb = OW'(index_b + RLIM);
  assign wc = OW'(index_c + RLIM);
  assign waddr_in = (AW'(wa) * SIDE + AW'(wb)) * SIDE + AW'(wc);
  assign ctl_in.valid = in_valid;
  assign ctl_in.wr    = (op == pgcf_pkg::OP_WRITE);
  assign ctl_in.wr_ok = (index_a >= -RLIM) && (index_a <= RLIM) &&
                        (index_b >= -RLIM) && (index_b <= RLIM) &&
                        (index_c >= -RLIM) && (index_c <= RLIM);

  pgcf_pkg::ctl_t              sb_ctl  [QB];
  logic [AW-1:0]               sb_addr [QB];
  logic [pgcf_pkg::CELL_W-1:0] sb_val  [QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QB; i++) begin
        sb_ctl[i] <= '0;
      end
    end else if (move) begin
      sb_ctl[0] <= ctl_in;
      for (int i = 1; i < QB; i++) begin
        sb_ctl[i] <= sb_ctl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      sb_addr[0] <= waddr_in;
      sb_val[0]  <= entry_value;
      for (int i = 1; i < QB; i++) begin
        sb_addr[i] <= sb_addr[i-1];
        sb_val[i]  <= sb_val[i-1];
      end
    end
  end

  logic [QB-1:0] quo_a, quo_b, quo_c;
  logic          neg_a, neg_b, neg_c;
  logic [GB-1:0] rem_a, rem_b, rem_c;
  logic [GB-1:0] fa, fb, fc;

  pgcf_lane #(.IB(IB), .GB(GB)) u_lane_a (
    .clk(clk), .move(move), .index(index_a), .size(eff_a),
    .quo(quo_a), .neg(neg_a), .fold(rem_a)
  );

  pgcf_lane #(.IB(IB), .GB(GB)) u_lane_b (
    .clk(clk), .move(move), .index(index_b), .size(eff_b),
    .quo(quo_b), .neg(neg_b), .fold(rem_b)
  );

  pgcf_lane #(.IB(IB), .GB(GB)) u_lane_c (
    .clk(clk), .move(move), .index(index_c), .size(eff_c),
    .quo(quo_c), .neg(neg_c), .fold(rem_c)
  );

  pgcf_merge #(.QB(QB), .GB(GB), .OW(OW), .AW(AW), .R(MAX_RADIUS)) u_merge (
    .clk(clk), .rst(rst), .move(move),
    .ctl(sb_ctl[QB-1]), .waddr(sb_addr[QB-1]), .wdata(sb_val[QB-1]),
    .rad(rad),
    .quo_a(quo_a), .quo_b(quo_b), .quo_c(quo_c),
    .neg_a(neg_a), .neg_b(neg_b), .neg_c(neg_c),
    .rem_a(rem_a), .rem_b(rem_b), .rem_c(rem_c),
    .out_valid(out_valid), .outside(outside), .cell_number(cell_number),
    .fold_a(fa), .fold_b(fb), .fold_c(fc)
  );

  assign fold_a = FW'(fa);
  assign fold_b = FW'(fb);
  assign fold_c = FW'(fc);

endmodule
`default_nettype wire

[test/periodic_grid_cell_fold_test.sv]
// Self-checking testbench for the periodic grid cell fold block.
`timescale 1ns / 1ps
module periodic_grid_cell_fold_test;

  localparam int IDX_W = 17;
  localparam int RAD_MAX = 3;
  localparam int SIDE = 2 * RAD_MAX + 1;
  localparam int DEPTH = SIDE * SIDE * SIDE;
  localparam int GRID_MAX = 1024;
  localparam int SETTLE = IDX_W + 8;

  typedef struct packed {
    logic                        outside;
    logic [pgcf_pkg::CELL_W-1:0] cell_no;
    logic [pgcf_pkg::FOLD_W-1:0] fa;
    logic [pgcf_pkg::FOLD_W-1:0] fb;
    logic [pgcf_pkg::FOLD_W-1:0] fc;
  } fold_word_t;

  typedef struct {
    logic                        wr;
    logic signed [IDX_W-1:0]     a;
    logic signed [IDX_W-1:0]     b;
    logic signed [IDX_W-1:0]     c;
    logic [pgcf_pkg::CELL_W-1:0] ev;
    bit                          typed;
    fold_word_t                  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [pgcf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pgcf_pkg::SIZE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = pgcf_pkg::OP_RESOLVE;
  logic signed [IDX_W-1:0] index_a = '0, index_b = '0, index_c = '0;
  logic [pgcf_pkg::CELL_W-1:0] entry_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic outside;
  logic [pgcf_pkg::CELL_W-1:0] cell_number;
  logic [pgcf_pkg::FOLD_W-1:0] fold_a, fold_b, fold_c;

  // Mirror of the block's registers and cell table.
  logic [pgcf_pkg::SIZE_W-1:0] size_a = pgcf_pkg::SIZE_W'(1);
  logic [pgcf_pkg::SIZE_W-1:0] size_b = pgcf_pkg::SIZE_W'(1);
  logic [pgcf_pkg::SIZE_W-1:0] size_c = pgcf_pkg::SIZE_W'(1);
  logic [pgcf_pkg::RAD_W-1:0]  radius = pgcf_pkg::RAD_W'(1);
  logic [pgcf_pkg::CELL_W-1:0] cells [DEPTH];

  fold_word_t pending_folds[$];
  int fail_count = 0;
  bit quiet = 1'b0;

  periodic_grid_cell_fold i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint clip_size(logic [pgcf_pkg::SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > GRID_MAX) return GRID_MAX;
    return longint'(s);
  endfunction

  function automatic int cell_addr(longint qa, longint qb, longint qc);
    return int'(((qa + RAD_MAX) * SIDE + (qb + RAD_MAX)) * SIDE + (qc + RAD_MAX));
  endfunction

  function automatic void floor_fold(longint x, longint n, output longint q,
                                     output longint r);
    if (x < 0) q = -(((-x) - 1) / n + 1);
    else q = x / n;
    r = x - q * n;
  endfunction

  function automatic fold_word_t fold_index(longint xa, longint xb, longint xc);
    fold_word_t w;
    longint qa, qb, qc, ra, rb, rc, rad;
    floor_fold(xa, clip_size(size_a), qa, ra);
    floor_fold(xb, clip_size(size_b), qb, rb);
    floor_fold(xc, clip_size(size_c), qc, rc);
    rad = (radius > RAD_MAX) ? RAD_MAX : radius;
    w.outside = (qa > rad || -qa > rad || qb > rad || -qb > rad ||
                 qc > rad || -qc > rad);
    w.cell_no = w.outside ? '0 : cells[cell_addr(qa, qb, qc)];
    w.fa = ra[pgcf_pkg::FOLD_W-1:0];
    w.fb = rb[pgcf_pkg::FOLD_W-1:0];
    w.fc = rc[pgcf_pkg::FOLD_W-1:0];
    return w;
  endfunction

  function automatic int draw_gap();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Sends one word, and on acceptance records what it should produce.
  task automatic send_word(stim_row_t row);
    int gap;
    longint xa, xb, xc;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op = row.wr;
    index_a = row.a;
    index_b = row.b;
    index_c = row.c;
    entry_value = row.ev;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    xa = row.a;
    xb = row.b;
    xc = row.c;
    if (row.wr == pgcf_pkg::OP_WRITE) begin
      if (xa <= RAD_MAX && -xa <= RAD_MAX && xb <= RAD_MAX && -xb <= RAD_MAX &&
          xc <= RAD_MAX && -xc <= RAD_MAX)
        cells[cell_addr(xa, xb, xc)] = row.ev;
    end else begin
      pending_folds.push_back(row.typed ? row.want : fold_index(xa, xb, xc));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_folds.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [pgcf_pkg::CFG_IDX_W-1:0] idx,
                           logic [pgcf_pkg::SIZE_W-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      pgcf_pkg::REG_GRID_A: size_a = val;
      pgcf_pkg::REG_GRID_B: size_b = val;
      pgcf_pkg::REG_GRID_C: size_c = val;
      pgcf_pkg::REG_RADIUS: radius = val[pgcf_pkg::RAD_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [IDX_W-1:0] pick_index(
      logic [pgcf_pkg::SIZE_W-1:0] s);
    int span;
    if ($urandom_range(0, 4) == 0) return IDX_W'($urandom);
    span = (int'(radius) + 2) * int'(clip_size(s));
    return IDX_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    r.typed = 1'b0;
    r.want = '0;
    r.ev = pgcf_pkg::CELL_W'($urandom);
    if ($urandom_range(0, 5) == 0) begin
      r.wr = pgcf_pkg::OP_WRITE;
      if ($urandom_range(0, 5) == 0) begin
        r.a = IDX_W'($urandom);
        r.b = IDX_W'(int'($urandom_range(0, 8)) - 4);
        r.c = IDX_W'(int'($urandom_range(0, 8)) - 4);
      end else begin
        r.a = IDX_W'(int'($urandom_range(0, 6)) - 3);
        r.b = IDX_W'(int'($urandom_range(0, 6)) - 3);
        r.c = IDX_W'(int'($urandom_range(0, 6)) - 3);
      end
    end else begin
      r.wr = pgcf_pkg::OP_RESOLVE;
      r.a = pick_index(size_a);
      r.b = pick_index(size_b);
      r.c = pick_index(size_c);
    end
    return r;
  endfunction

  // Receiving side: random stall before each result word, then check it.
  initial begin
    int n;
    fold_word_t got, want;
    forever begin
      n = draw_gap();
      repeat (n) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      got = '{outside, cell_number, fold_a, fold_b, fold_c};
      if (pending_folds.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = pending_folds.pop_front();
        if (got.outside !== want.outside) begin
          $error("outside: expected %0d, got %0d", want.outside, got.outside);
          fail_count++;
        end
        if (got.cell_no !== want.cell_no) begin
          $error("cell_number: expected %0d, got %0d", want.cell_no, got.cell_no);
          fail_count++;
        end
        if (got.fa !== want.fa) begin
          $error("fold_a: expected %0d, got %0d", want.fa, got.fa);
          fail_count++;
        end
        if (got.fb !== want.fb) begin
          $error("fold_b: expected %0d, got %0d", want.fb, got.fb);
          fail_count++;
        end
        if (got.fc !== want.fc) begin
          $error("fold_c: expected %0d, got %0d", want.fc, got.fc);
          fail_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t directed[$];
    stim_row_t row;
    logic [pgcf_pkg::SIZE_W-1:0] settings[8][4];
    directed = '{
      '{pgcf_pkg::OP_WRITE, 17'sd4, 17'sd0, 17'sd0, 10'd5, 1'b0, '0},
      '{pgcf_pkg::OP_WRITE, -17'sd65536, 17'sd0, 17'sd0, 10'd6, 1'b0, '0},
      '{pgcf_pkg::OP_WRITE, 17'sd1, -17'sd1, 17'sd0, 10'd1023, 1'b0, '0},
      '{pgcf_pkg::OP_WRITE, 17'sd0, 17'sd0, 17'sd0, 10'd0, 1'b0, '0},
      '{pgcf_pkg::OP_WRITE, -17'sd3, 17'sd3, -17'sd3, 10'd1023, 1'b0, '0},
      '{pgcf_pkg::OP_RESOLVE, 17'sd1, -17'sd1, 17'sd0, 10'd0, 1'b1,
        '{1'b0, 10'd1023, 10'd0, 10'd0, 10'd0}},
      '{pgcf_pkg::OP_RESOLVE, 17'sd0, 17'sd0, 17'sd0, 10'd0, 1'b1,
        '{1'b0, 10'd0, 10'd0, 10'd0, 10'd0}},
      '{pgcf_pkg::OP_RESOLVE, 17'sd2, 17'sd0, 17'sd0, 10'd0, 1'b1,
        '{1'b1, 10'd0, 10'd0, 10'd0, 10'd0}},
      '{pgcf_pkg::OP_RESOLVE, 17'sd0, 17'sd0, -17'sd2, 10'd0, 1'b1,
        '{1'b1, 10'd0, 10'd0, 10'd0, 10'd0}},
      '{pgcf_pkg::OP_RESOLVE, -17'sd65536, 17'sd65535, 17'sd0, 10'd0, 1'b1,
        '{1'b1, 10'd0, 10'd0, 10'd0, 10'd0}},
      '{pgcf_pkg::OP_RESOLVE, -17'sd1, 17'sd1, -17'sd1, 10'd0, 1'b0, '0},
      '{pgcf_pkg::OP_RESOLVE, 17'sd65535, -17'sd65536, -17'sd1, 10'd0, 1'b0, '0},
      '{pgcf_pkg::OP_RESOLVE, -17'sd21845, 17'sd21845, 17'sd0, 10'd0, 1'b0, '0}
    };
    // Sizes of zero and beyond the maximum are clipped; both radius extremes.
    settings = '{
      '{11'd0, 11'd2047, 11'd5, 11'd0},
      '{11'd1024, 11'd1024, 11'd1024, 11'd3},
      '{11'd3, 11'd7, 11'd1, 11'd2},
      '{11'd1, 11'd1, 11'd1, 11'd3},
      '{11'd1025, 11'd0, 11'd2, 11'd1},
      '{11'd13, 11'd600, 11'd9, 11'd3},
      '{11'd2, 11'd2, 11'd2, 11'd0},
      '{11'd37, 11'd4, 11'd1023, 11'd2}
    };
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill every table entry so that no resolve ever reads an unwritten one.
    quiet = 1'b1;
    for (int a = -RAD_MAX; a <= RAD_MAX; a++)
      for (int b = -RAD_MAX; b <= RAD_MAX; b++)
        for (int c = -RAD_MAX; c <= RAD_MAX; c++) begin
          row = '{pgcf_pkg::OP_WRITE, IDX_W'(a), IDX_W'(b), IDX_W'(c),
                  pgcf_pkg::CELL_W'($urandom), 1'b0, '0};
          send_word(row);
        end
    quiet = 1'b0;
    foreach (directed[i]) send_word(directed[i]);
    drain();

    foreach (settings[p]) begin
      for (int k = 0; k < 4; k++)
        write_reg(pgcf_pkg::CFG_IDX_W'(k), settings[p][k]);
      quiet = (p % 3 == 1);
      repeat (160) send_word(random_row());
      drain();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pgcf_pkg.sv
rtl/pgcf_lane.sv
rtl/pgcf_merge.sv
rtl/periodic_grid_cell_fold.sv
test/periodic_grid_cell_fold_test.sv
